// File: hdl/integer_stack_machine_top_macros.svh
`ifndef INTEGER_STACK_MACHINE_TOP_MACROS_SVH
`define INTEGER_STACK_MACHINE_TOP_MACROS_SVH

// Same-cycle implication, sampled on the block clock and quiet while reset is held.
`define ISM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the block clock and quiet while reset is held.
`define ISM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ism_pkg.sv
package ism_pkg;

    // Stack geometry and field widths.
    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int DEPTH_W     = 7;
    localparam int CMD_W       = 4;
    localparam int STATUS_W    = 2;
    localparam int CNT_W       = $clog2(DATA_W);

    // Instruction codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_CONST = 4'd0,
        CMD_ADD   = 4'd1,
        CMD_SUB   = 4'd2,
        CMD_MUL   = 4'd3,
        CMD_DIV   = 4'd4,
        CMD_MAX   = 4'd5,
        CMD_MIN   = 4'd6,
        CMD_NEG   = 4'd7,
        CMD_DUP   = 4'd8,
        CMD_SWAP  = 4'd9
    } t_ism_cmd;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } t_ism_status;

    // Input beat.
    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] operand;
    } t_ism_in;

    // Output beat.
    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic [DEPTH_W-1:0]       depth;
        logic [STATUS_W-1:0]      status;
    } t_ism_out;

    // Instruction sequencer states.
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_DECODE,
        SEQ_READ,
        SEQ_WAIT,
        SEQ_SWAP,
        SEQ_DONE
    } t_ism_seq_state;

    // Arithmetic unit states.
    typedef enum logic [2:0] {
        ALU_IDLE,
        ALU_ABS_N,
        ALU_DIV,
        ALU_FIX,
        ALU_MUL,
        ALU_DONE
    } t_ism_alu_state;

    // Request from the sequencer to the arithmetic unit.
    typedef struct packed {
        logic              start;
        t_ism_cmd          op;
        logic [DATA_W-1:0] top;
        logic [DATA_W-1:0] nxt;
    } t_ism_alu_req;

    // Response from the arithmetic unit.
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } t_ism_alu_rsp;

endpackage

// File: hdl/ism_ram.sv
module ism_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/ism_alu.sv
module ism_alu import ism_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_ism_alu_req i_req,
    output t_ism_alu_rsp o_rsp
);

    t_ism_alu_state    r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DATA_W-1:0] r_x, n_x;
    logic [DATA_W-1:0] r_y, n_y;
    logic [DATA_W-1:0] r_z, n_z;
    logic              r_neg, n_neg;
    logic [DATA_W:0]   add_a, add_b, add_sum;
    logic              add_sub;
    logic              last_step;

    // The one shared adder. Bit DATA_W of a subtraction flags a < b.
    assign add_sum   = add_a + (add_sub ? ~add_b : add_b) + {{DATA_W{1'b0}}, add_sub};
    assign last_step = (r_cnt == CNT_W'(DATA_W - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ALU_IDLE: begin
                if (i_req.start) begin
                    case (i_req.op)
                        CMD_MUL: n_state = ALU_MUL;
                        CMD_DIV: n_state = ALU_ABS_N;
                        default: n_state = ALU_DONE;
                    endcase
                end
            end
            ALU_ABS_N: n_state = ALU_DIV;
            ALU_DIV: begin
                if (last_step) begin
                    n_state = ALU_FIX;
                end
            end
            ALU_FIX: n_state = ALU_DONE;
            ALU_MUL: begin
                if (last_step) begin
                    n_state = ALU_DONE;
                end
            end
            ALU_DONE: n_state = ALU_IDLE;
            default:  n_state = ALU_IDLE;
        endcase
    end

    // Adder operand selection and working register updates.
    always_comb begin
        add_a        = '0;
        add_b        = '0;
        add_sub      = 1'b0;
        n_x          = r_x;
        n_y          = r_y;
        n_z          = r_z;
        n_cnt        = r_cnt;
        n_neg        = r_neg;
        o_rsp.done   = 1'b0;
        o_rsp.result = r_x;
        case (r_state)
            ALU_IDLE: begin
                n_cnt = '0;
                // Operations other than MUL and DIV get their result here; the divide
                // takes the dividend magnitude in this cycle.
                case (i_req.op)
                    CMD_ADD: begin
                        add_a = {1'b0, i_req.top};
                        add_b = {1'b0, i_req.nxt};
                    end
                    CMD_SUB, CMD_MAX, CMD_MIN: begin
                        add_a   = {i_req.top[DATA_W-1], i_req.top};
                        add_b   = {i_req.nxt[DATA_W-1], i_req.nxt};
                        add_sub = 1'b1;
                    end
                    CMD_NEG, CMD_DIV: begin
                        add_b   = {1'b0, i_req.top};
                        add_sub = 1'b1;
                    end
                    default: begin
                        add_sub = 1'b0;
                    end
                endcase
                case (i_req.op)
                    CMD_MAX: n_x = add_sum[DATA_W] ? i_req.nxt : i_req.top;
                    CMD_MIN: n_x = add_sum[DATA_W] ? i_req.top : i_req.nxt;
                    CMD_MUL: begin
                        n_x = '0;
                        n_y = i_req.top;
                        n_z = i_req.nxt;
                    end
                    CMD_DIV: begin
                        n_z   = i_req.top[DATA_W-1] ? add_sum[DATA_W-1:0] : i_req.top;
                        n_y   = i_req.nxt;
                        n_neg = i_req.top[DATA_W-1] ^ i_req.nxt[DATA_W-1];
                    end
                    default: n_x = add_sum[DATA_W-1:0];
                endcase
            end
            ALU_ABS_N: begin
                // Divisor magnitude; the remainder starts at zero.
                add_b   = {1'b0, r_y};
                add_sub = 1'b1;
                n_y     = r_y[DATA_W-1] ? add_sum[DATA_W-1:0] : r_y;
                n_x     = '0;
            end
            ALU_DIV: begin
                // One restoring step: shift in a dividend bit, try to subtract.
                add_a   = {1'b0, r_x[DATA_W-2:0], r_z[DATA_W-1]};
                add_b   = {1'b0, r_y};
                add_sub = 1'b1;
                n_x     = add_sum[DATA_W] ? add_a[DATA_W-1:0] : add_sum[DATA_W-1:0];
                n_z     = {r_z[DATA_W-2:0], ~add_sum[DATA_W]};
                n_cnt   = r_cnt + CNT_W'(1);
            end
            ALU_FIX: begin
                // Quotient sign follows the operand signs.
                add_b   = {1'b0, r_z};
                add_sub = 1'b1;
                n_x     = r_neg ? add_sum[DATA_W-1:0] : r_z;
            end
            ALU_MUL: begin
                // One shift-and-add step; only the low word is kept.
                add_a = {1'b0, r_x};
                add_b = r_z[0] ? {1'b0, r_y} : '0;
                n_x   = add_sum[DATA_W-1:0];
                n_y   = {r_y[DATA_W-2:0], 1'b0};
                n_z   = {1'b0, r_z[DATA_W-1:1]};
                n_cnt = r_cnt + CNT_W'(1);
            end
            ALU_DONE: begin
                o_rsp.done = 1'b1;
            end
            default: begin
                o_rsp.done = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ALU_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
        r_neg <= n_neg;
    end

endmodule

// File: hdl/integer_stack_machine_top.sv
// Channel  Direction  Handshake                 Beat
// input    in         i_in_valid / o_in_stall   i_in_data  (t_ism_in: cmd, operand)
// output   out        o_out_valid / i_out_stall o_out_data (t_ism_out: top_value, depth, status)
//
// One instruction is in flight at a time; each produces exactly one output beat.
// CONST, DUP, unknown codes, underflow and overflow end after decode; NEG goes on to the unit;
// two-operand work reads N first; MUL and DIV run on the shared adder, one bit a cycle.
// The top of stack is held in a register and the whole stack is mirrored in a RAM.
// Reset is synchronous and active low; it empties the stack but leaves the RAM as is.
// A new beat is taken while an earlier result still waits under i_out_stall.
module integer_stack_machine_top import ism_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_ism_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_ism_out o_out_data
);

    t_ism_seq_state    r_state, n_state;
    logic [SP_W-1:0]   r_sp, n_sp;
    logic [DATA_W-1:0] r_top, n_top;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [DATA_W-1:0] r_opnd, n_opnd;
    t_ism_status       r_status, n_status;
    logic              r_out_valid, n_out_valid;
    t_ism_out          r_out, n_out;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    t_ism_alu_req      alu_req;
    t_ism_alu_rsp      alu_rsp;

    logic              sp_empty;
    logic              sp_lt2;
    logic              sp_full;
    logic [ADDR_W-1:0] addr_top;
    logic [ADDR_W-1:0] addr_nxt;
    logic [ADDR_W-1:0] addr_push;
    logic              out_free;

    // Stack pointer views.
    assign sp_empty  = (r_sp == '0);
    assign sp_lt2    = (r_sp < SP_W'(2));
    assign sp_full   = (r_sp >= SP_W'(STACK_DEPTH));
    assign addr_top  = ADDR_W'(r_sp - SP_W'(1));
    assign addr_nxt  = ADDR_W'(r_sp - SP_W'(2));
    assign addr_push = ADDR_W'(r_sp);
    assign out_free  = !r_out_valid || !i_out_stall;

    // Stack store.
    ism_ram #(
        .WIDTH(DATA_W),
        .DEPTH(STACK_DEPTH)
    ) u_ism_ram (
        .i_clk    (i_clk),
        .i_wr_en  (ram_we),
        .i_wr_addr(ram_waddr),
        .i_wr_data(ram_wdata),
        .i_rd_addr(ram_raddr),
        .o_rd_data(ram_rdata)
    );

    // Shared arithmetic unit.
    ism_alu u_ism_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (alu_req),
        .o_rsp  (alu_rsp)
    );

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            SEQ_IDLE: begin
                if (i_in_valid) begin
                    n_state = SEQ_DECODE;
                end
            end
            SEQ_DECODE: begin
                case (r_cmd)
                    CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MAX, CMD_MIN, CMD_SWAP: begin
                        n_state = sp_lt2 ? SEQ_DONE : SEQ_READ;
                    end
                    CMD_NEG: n_state = sp_empty ? SEQ_DONE : SEQ_WAIT;
                    default: n_state = SEQ_DONE;
                endcase
            end
            SEQ_READ: begin
                if (r_cmd == CMD_SWAP) begin
                    n_state = SEQ_SWAP;
                end else if (r_cmd == CMD_DIV && ram_rdata == '0) begin
                    n_state = SEQ_DONE;
                end else begin
                    n_state = SEQ_WAIT;
                end
            end
            SEQ_WAIT: begin
                if (alu_rsp.done) begin
                    n_state = SEQ_DONE;
                end
            end
            SEQ_SWAP: n_state = SEQ_DONE;
            SEQ_DONE: begin
                if (out_free) begin
                    n_state = SEQ_IDLE;
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

    // Sequencer outputs: stack updates, RAM and unit control, output register.
    always_comb begin
        o_in_stall    = (r_state != SEQ_IDLE);
        n_sp          = r_sp;
        n_top         = r_top;
        n_cmd         = r_cmd;
        n_opnd        = r_opnd;
        n_status      = r_status;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out         = r_out;
        ram_we        = 1'b0;
        ram_waddr     = addr_push;
        ram_wdata     = r_top;
        ram_raddr     = addr_nxt;
        alu_req.start = 1'b0;
        alu_req.op    = t_ism_cmd'(r_cmd);
        alu_req.top   = r_top;
        alu_req.nxt   = ram_rdata;
        case (r_state)
            SEQ_IDLE: begin
                if (i_in_valid) begin
                    n_cmd    = i_in_data.cmd;
                    n_opnd   = i_in_data.operand;
                    n_status = ST_OK;
                end
            end
            SEQ_DECODE: begin
                // Depth checks; pushes complete here, two-operand work reads N.
                case (r_cmd)
                    CMD_CONST: begin
                        if (sp_full) begin
                            n_status = ST_OVER;
                        end else begin
                            ram_we    = 1'b1;
                            ram_wdata = r_opnd;
                            n_top     = r_opnd;
                            n_sp      = r_sp + SP_W'(1);
                        end
                    end
                    CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MAX, CMD_MIN, CMD_SWAP: begin
                        if (sp_lt2) begin
                            n_status = ST_UNDER;
                        end
                    end
                    CMD_NEG: begin
                        if (sp_empty) begin
                            n_status = ST_UNDER;
                        end else begin
                            alu_req.start = 1'b1;
                        end
                    end
                    CMD_DUP: begin
                        if (sp_empty) begin
                            n_status = ST_UNDER;
                        end else if (sp_full) begin
                            n_status = ST_OVER;
                        end else begin
                            ram_we = 1'b1;
                            n_sp   = r_sp + SP_W'(1);
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            SEQ_READ: begin
                // N is on the RAM read port in this cycle.
                if (r_cmd == CMD_SWAP) begin
                    ram_we    = 1'b1;
                    ram_waddr = addr_nxt;
                    n_top     = ram_rdata;
                end else if (r_cmd == CMD_DIV && ram_rdata == '0) begin
                    n_status = ST_DIVZ;
                end else begin
                    alu_req.start = 1'b1;
                end
            end
            SEQ_WAIT: begin
                if (alu_rsp.done) begin
                    ram_we    = 1'b1;
                    ram_wdata = alu_rsp.result;
                    n_top     = alu_rsp.result;
                    if (r_cmd == CMD_NEG) begin
                        ram_waddr = addr_top;
                    end else begin
                        ram_waddr = addr_nxt;
                        n_sp      = r_sp - SP_W'(1);
                    end
                end
            end
            SEQ_SWAP: begin
                // The register already holds the old N; it goes to the top slot.
                ram_we    = 1'b1;
                ram_waddr = addr_top;
            end
            SEQ_DONE: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.top_value  = sp_empty ? '0 : r_top;
                    n_out.depth      = DEPTH_W'(r_sp);
                    n_out.status     = r_status;
                end
            end
            default: begin
                n_out_valid = r_out_valid && i_out_stall;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SEQ_IDLE;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_top    <= n_top;
        r_cmd    <= n_cmd;
        r_opnd   <= n_opnd;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: hdl/ism_checker.sv
`include "integer_stack_machine_top_macros.svh"

module ism_checker import ism_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_stall,
    input t_ism_in  i_in_data,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_ism_out o_out_data
);

    // An accepted beat makes the block busy in the next cycle.
    `ISM_ASSERT_NEXT(a_accept_busy, i_in_valid && !o_in_stall, o_in_stall, "busy not raised after accept")

    // A stalled result beat holds.
    `ISM_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result changed")

    // An empty stack reports a zero top.
    `ISM_ASSERT_IMPL(a_empty_zero, o_out_valid && o_out_data.depth == '0, o_out_data.top_value == '0, "empty stack with nonzero top")

    // Overflow is only reported on a full stack.
    `ISM_ASSERT_IMPL(a_over_full, o_out_valid && o_out_data.status == ST_OVER, o_out_data.depth == DEPTH_W'(STACK_DEPTH), "overflow below full depth")

    // Underflow is only reported on a stack with fewer than two entries.
    `ISM_ASSERT_IMPL(a_under_low, o_out_valid && o_out_data.status == ST_UNDER, o_out_data.depth < DEPTH_W'(2), "underflow with two or more entries")

endmodule

bind integer_stack_machine_top ism_checker u_ism_checker (.*);

// File: test/integer_stack_machine_top_tb.sv
`timescale 1ns / 1ps

module integer_stack_machine_top_tb;
    import ism_pkg::*;

    localparam int                CLK_HALF     = 6;
    localparam int                RESET_CYCLES = 12;
    localparam int                RANDOM_BEATS = 1100;
    localparam int                CYCLE_LIMIT  = 1_000_000;
    localparam int                SETTLE_WAIT  = 80;
    localparam int                REPORT_LIMIT = 10;
    localparam int                CODE_SPACE   = 1 << CMD_W;
    localparam logic [DATA_W-1:0] INT_MIN_VAL  = 32'h8000_0000;
    localparam logic [DATA_W-1:0] INT_MAX_VAL  = 32'h7fff_ffff;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_stall;
    t_ism_in  i_in_data;
    logic     o_out_valid;
    logic     i_out_stall;
    t_ism_out o_out_data;

    // Instruction beats waiting to be driven, and results owed by the block.
    t_ism_in  program_q[$];
    t_ism_out owed_results_q[$];

    // Shadow copy of the stack, advanced as each instruction is accepted.
    logic [DATA_W-1:0] shadow_stack[STACK_DEPTH];
    int                shadow_depth;

    // Stack depth as guessed while the program is being built.
    int plan_depth;
    int known_codes;
    int beats_queued;
    int beats_sent;
    int results_checked;
    int mismatches;
    int cycle_count;
    int deepest;
    int status_seen[4];
    int in_gap;
    int in_calm;
    int stall_left;
    int out_calm;
    t_ism_out want_beat;

    integer_stack_machine_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    // Run one instruction on the shadow stack and return the result it owes.
    function automatic t_ism_out execute_on_shadow(t_ism_in beat);
        t_ism_out          res;
        t_ism_status       st;
        logic [DATA_W-1:0] t;
        logic [DATA_W-1:0] n;
        logic [DATA_W-1:0] r;
        logic [DATA_W-1:0] mag_t;
        logic [DATA_W-1:0] mag_n;
        logic [DATA_W-1:0] quo;
        st = ST_OK;
        r  = '0;
        t  = (shadow_depth > 0) ? shadow_stack[shadow_depth-1] : '0;
        n  = (shadow_depth > 1) ? shadow_stack[shadow_depth-2] : '0;
        case (beat.cmd)
            CMD_CONST: begin
                if (shadow_depth >= STACK_DEPTH) begin
                    st = ST_OVER;
                end else begin
                    shadow_stack[shadow_depth] = beat.operand;
                    shadow_depth++;
                end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MAX, CMD_MIN: begin
                if (shadow_depth < 2) begin
                    st = ST_UNDER;
                end else if (beat.cmd == CMD_DIV && n == '0) begin
                    st = ST_DIVZ;
                end else begin
                    case (beat.cmd)
                        CMD_ADD: r = t + n;
                        CMD_SUB: r = t - n;
                        CMD_MUL: r = t * n;
                        CMD_DIV: begin
                            // Divide magnitudes, then fix the sign; this truncates
                            // toward zero and leaves the most negative value by -1 as is.
                            mag_t = t[DATA_W-1] ? -t : t;
                            mag_n = n[DATA_W-1] ? -n : n;
                            quo   = mag_t / mag_n;
                            r     = (t[DATA_W-1] ^ n[DATA_W-1]) ? -quo : quo;
                        end
                        CMD_MAX: r = ($signed(t) < $signed(n)) ? n : t;
                        default: r = ($signed(t) < $signed(n)) ? t : n;
                    endcase
                    shadow_stack[shadow_depth-2] = r;
                    shadow_depth--;
                end
            end
            CMD_NEG: begin
                if (shadow_depth < 1) begin
                    st = ST_UNDER;
                end else begin
                    shadow_stack[shadow_depth-1] = -t;
                end
            end
            CMD_DUP: begin
                if (shadow_depth < 1) begin
                    st = ST_UNDER;
                end else if (shadow_depth >= STACK_DEPTH) begin
                    st = ST_OVER;
                end else begin
                    shadow_stack[shadow_depth] = t;
                    shadow_depth++;
                end
            end
            CMD_SWAP: begin
                if (shadow_depth < 2) begin
                    st = ST_UNDER;
                end else begin
                    shadow_stack[shadow_depth-1] = n;
                    shadow_stack[shadow_depth-2] = t;
                end
            end
            default: begin
                // Unused codes leave the stack alone and report success.
            end
        endcase
        res.top_value = (shadow_depth > 0) ? shadow_stack[shadow_depth-1] : '0;
        res.depth     = DEPTH_W'(shadow_depth);
        res.status    = st;
        return res;
    endfunction

    // Append one instruction to the program and track the depth it should leave.
    function automatic void queue_beat(logic [CMD_W-1:0] code, logic [DATA_W-1:0] value);
        t_ism_in beat;
        beat.cmd     = code;
        beat.operand = value;
        program_q.push_back(beat);
        beats_queued++;
        case (code)
            CMD_CONST: if (plan_depth < STACK_DEPTH) plan_depth++;
            CMD_DUP:   if (plan_depth > 0 && plan_depth < STACK_DEPTH) plan_depth++;
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MAX, CMD_MIN: begin
                if (plan_depth >= 2) plan_depth--;
            end
            default: ;
        endcase
        if (code <= CMD_SWAP) known_codes++;
    endfunction

    // Operand values lean toward the extremes and small numbers.
    function automatic logic [DATA_W-1:0] rand_operand();
        case ($urandom_range(0, 9))
            0:       return INT_MIN_VAL;
            1:       return INT_MAX_VAL;
            2:       return '1;
            3:       return '0;
            4, 5:    return DATA_W'(int'($urandom_range(0, 40)) - 20);
            default: return $urandom();
        endcase
    endfunction

    // Idle length for either side: mostly none or short, now and then long,
    // with calm stretches where nothing idles at all.
    function automatic int next_gap(inout int calm);
        int pick;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm = $urandom_range(30, 120);
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Driver: offers the next beat from the program once the last one moved.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                owed_results_q.push_back(execute_on_shadow(i_in_data));
                beats_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (program_q.size() > 0) begin
                    i_in_data  <= program_q.pop_front();
                    i_in_valid <= 1'b1;
                    in_gap = next_gap(in_calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each result beat with the oldest owed result and
    // applies random back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (owed_results_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("[%0t] unexpected result: top %0d depth %0d status %0d",
                                 $realtime, o_out_data.top_value, o_out_data.depth,
                                 o_out_data.status);
                    end
                end else begin
                    want_beat = owed_results_q.pop_front();
                    results_checked++;
                    status_seen[want_beat.status]++;
                    if (want_beat.depth > deepest) deepest = want_beat.depth;
                    if (o_out_data.top_value !== want_beat.top_value ||
                        o_out_data.depth !== want_beat.depth ||
                        o_out_data.status !== want_beat.status) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("[%0t] result %0d: expected top %0d depth %0d status %0d",
                                     $realtime, results_checked, want_beat.top_value,
                                     want_beat.depth, want_beat.status);
                            $display("[%0t] result %0d: got top %0d depth %0d status %0d",
                                     $realtime, results_checked, o_out_data.top_value,
                                     o_out_data.depth, o_out_data.status);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                stall_left = next_gap(out_calm);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out with %0d of %0d beats sent and %0d results owed.",
                     beats_sent, beats_queued, owed_results_q.size());
            $display("FAIL integer_stack_machine_top");
            $finish;
        end
    end

    initial begin
        int kind;
        int pick;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_out_stall  = 1'b0;
        shadow_depth = 0;
        plan_depth   = 0;

        // Directed part: underflow on an empty and a one-entry stack, wrapping,
        // the most negative value divided by -1, a zero divisor, truncation,
        // multiply overflow, max, min, subtract order and an unused code.
        queue_beat(CMD_ADD, '0);
        queue_beat(CMD_NEG, '0);
        queue_beat(CMD_DUP, '0);
        queue_beat(CMD_CONST, INT_MAX_VAL);
        queue_beat(CMD_SUB, '0);
        queue_beat(CMD_SWAP, '0);
        queue_beat(CMD_CONST, 32'd1);
        queue_beat(CMD_ADD, '1);
        queue_beat(CMD_NEG, '0);
        queue_beat(CMD_CONST, '1);
        queue_beat(CMD_SWAP, '0);
        queue_beat(CMD_DIV, '0);
        queue_beat(CMD_CONST, '0);
        queue_beat(CMD_SWAP, '0);
        queue_beat(CMD_DIV, '0);
        queue_beat(CMD_CONST, 32'd2);
        queue_beat(CMD_CONST, -32'sd7);
        queue_beat(CMD_DIV, '0);
        queue_beat(CMD_CONST, 32'h0001_0000);
        queue_beat(CMD_DUP, '0);
        queue_beat(CMD_MUL, '0);
        queue_beat(CMD_CONST, -32'sd5);
        queue_beat(CMD_CONST, 32'd3);
        queue_beat(CMD_MAX, '0);
        queue_beat(CMD_CONST, -32'sd5);
        queue_beat(CMD_MIN, '0);
        queue_beat(CMD_CONST, 32'd10);
        queue_beat(CMD_SUB, '0);
        queue_beat(CMD_W'(CMD_SWAP + 1), $urandom());

        // Random part, built from short programs so that real arithmetic runs,
        // with fills to overflow, drains to underflow, division cases and noise.
        while (known_codes < RANDOM_BEATS + 29) begin
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                repeat ($urandom_range(3, 12)) begin
                    pick = $urandom_range(0, 99);
                    if (plan_depth < 2 && pick < 75) begin
                        queue_beat(CMD_CONST, rand_operand());
                    end else if (pick < 30) begin
                        queue_beat(CMD_CONST, rand_operand());
                    end else if (pick < 75) begin
                        queue_beat(CMD_W'($urandom_range(CMD_ADD, CMD_MIN)), rand_operand());
                    end else if (pick < 83) begin
                        queue_beat(CMD_NEG, rand_operand());
                    end else if (pick < 91) begin
                        queue_beat(CMD_DUP, rand_operand());
                    end else begin
                        queue_beat(CMD_SWAP, rand_operand());
                    end
                end
            end else if (kind < 70) begin
                repeat (STACK_DEPTH - plan_depth + $urandom_range(1, 4)) begin
                    if (plan_depth > 0 && $urandom_range(0, 3) == 0) begin
                        queue_beat(CMD_DUP, rand_operand());
                    end else begin
                        queue_beat(CMD_CONST, rand_operand());
                    end
                end
            end else if (kind < 77) begin
                repeat (plan_depth + $urandom_range(1, 3)) begin
                    queue_beat(CMD_W'($urandom_range(CMD_ADD, CMD_MIN)), rand_operand());
                end
            end else if (kind < 92) begin
                case ($urandom_range(0, 4))
                    0:       queue_beat(CMD_CONST, '0);
                    1:       queue_beat(CMD_CONST, '1);
                    2:       queue_beat(CMD_CONST, 32'd1);
                    default: queue_beat(CMD_CONST, rand_operand());
                endcase
                queue_beat(CMD_CONST, ($urandom_range(0, 2) == 0) ? INT_MIN_VAL : rand_operand());
                queue_beat(CMD_DIV, rand_operand());
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    queue_beat(CMD_W'($urandom_range(0, CODE_SPACE - 1)), $urandom());
                end
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every beat to go in and every owed result to come out.
        while (beats_sent < beats_queued) @(posedge i_clk);
        while (owed_results_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);

        $display("Checked %0d results from %0d beats in %0d cycles, deepest stack %0d.",
                 results_checked, beats_sent, cycle_count, deepest);
        $display("Outcomes: %0d ok, %0d underflow, %0d overflow, %0d zero divisor, %0d mismatches.",
                 status_seen[ST_OK], status_seen[ST_UNDER], status_seen[ST_OVER],
                 status_seen[ST_DIVZ], mismatches);
        if (mismatches == 0) begin
            $display("PASS integer_stack_machine_top");
        end else begin
            $display("FAIL integer_stack_machine_top");
        end
        $finish;
    end

endmodule
